// ----- hw/rtl/cbz_pkg.sv -----
package cbz_pkg;

  // width of one slice of a wide multiplicand
  localparam int LIMB_W = 24;

  // configuration register index
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CTRL_POINT_0 = 3'd0;
  localparam cfg_idx_t CFG_CTRL_POINT_1 = 3'd1;
  localparam cfg_idx_t CFG_CTRL_POINT_2 = 3'd2;
  localparam cfg_idx_t CFG_CTRL_POINT_3 = 3'd3;

  localparam int NUM_CTRL_POINTS = 4;
  localparam int NUM_AXES        = 3;

endpackage

// ----- hw/rtl/cbz_axis.sv -----
module cbz_axis #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic signed [COORD_WIDTH-1:0] c0_i,
  input  logic signed [COORD_WIDTH-1:0] c1_i,
  input  logic signed [COORD_WIDTH-1:0] c2_i,
  input  logic signed [COORD_WIDTH-1:0] c3_i,
  input  logic        [T_FRAC_BITS:0]   t_s0_i,
  input  logic        [T_FRAC_BITS:0]   t_s2_i,
  input  logic        [T_FRAC_BITS:0]   t_s4_i,
  output logic signed [COORD_WIDTH-1:0] point_o,
  output logic signed [COORD_WIDTH+2:0] slope_o,
  output logic signed [COORD_WIDTH+4:0] bend_o
);
  import cbz_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int T   = T_FRAC_BITS;
  localparam int TW  = T + 1;
  localparam int AW  = CW + 4;
  localparam int PW  = AW + TW + 1;
  localparam int HW  = AW + T + 2;
  localparam int BNW = AW + T + 3;
  localparam int SW  = CW + 3;
  localparam int BW  = CW + 5;
  localparam int PPW = LIMB_W + TW + 1;
  localparam int NL1 = (HW + LIMB_W - 1) / LIMB_W;
  localparam int XW1 = NL1 * LIMB_W;
  localparam int MW2 = HW + TW + 1;
  localparam int H2W = CW + 2 * T + 6;
  localparam int NL2 = (H2W + LIMB_W - 1) / LIMB_W;
  localparam int XW2 = NL2 * LIMB_W;
  localparam int MW3 = H2W + TW + 1;

  // power basis coefficients; the user must keep them stable while items are in flight, the block does not enforce it
  logic signed [AW-1:0] a0, a1, a2, a3;
  logic signed [AW-1:0] e0, e1, e2, e3, d10, d2;

  assign e0  = AW'(c0_i);
  assign e1  = AW'(c1_i);
  assign e2  = AW'(c2_i);
  assign e3  = AW'(c3_i);
  assign d10 = e1 - e0;
  assign d2  = e0 - (e1 <<< 1) + e2;
  assign a0  = e0;
  assign a1  = d10 + (d10 <<< 1);
  assign a2  = d2 + (d2 <<< 1);
  assign a3  = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);

  logic signed [TW:0] t0s, t2s, t4s;
  assign t0s = $signed({1'b0, t_s0_i});
  assign t2s = $signed({1'b0, t_s2_i});
  assign t4s = $signed({1'b0, t_s4_i});

  // stage 1: cubic coefficient times t
  logic signed [PW-1:0] p1_d, p1_q;
  assign p1_d = a3 * t0s;

  // stage 2: inner horner sums and rounded second derivative
  logic signed [HW-1:0]  h1_d, h1_q, q1_d, q1_q;
  logic signed [BNW-1:0] bn;
  logic signed [BW-1:0]  bend2_d, bend2_q, bend3_q, bend4_q, bend5_q, bend_q;

  always_comb begin
    h1_d    = HW'(p1_q) + (HW'(a2) <<< T);
    q1_d    = HW'(p1_q) + (HW'(p1_q) <<< 1) + (HW'(a2) <<< (T + 1));
    bn      = (BNW'(p1_q) <<< 1) + (BNW'(p1_q) <<< 2) + (BNW'(a2) <<< (T + 1))
              + (BNW'(1) <<< (T - 1));
    bend2_d = BW'(bn >>> T);
  end

  // stage 3: sliced products of both inner sums with t
  logic signed [XW1-1:0] h_ext, q_ext;
  logic signed [PPW-1:0] pph_d [NL1];
  logic signed [PPW-1:0] pph_q [NL1];
  logic signed [PPW-1:0] ppq_d [NL1];
  logic signed [PPW-1:0] ppq_q [NL1];

  always_comb begin
    h_ext = XW1'(h1_q);
    q_ext = XW1'(q1_q);
    for (int i = 0; i < NL1; i++) begin
      if (i == NL1 - 1) begin
        pph_d[i] = $signed(h_ext[i*LIMB_W +: LIMB_W]) * t2s;
        ppq_d[i] = $signed(q_ext[i*LIMB_W +: LIMB_W]) * t2s;
      end else begin
        pph_d[i] = $signed({1'b0, h_ext[i*LIMB_W +: LIMB_W]}) * t2s;
        ppq_d[i] = $signed({1'b0, q_ext[i*LIMB_W +: LIMB_W]}) * t2s;
      end
    end
  end

  // stage 4: gather slices, add linear term, round first derivative
  logic signed [MW2-1:0] sum_h, sum_q;
  logic signed [H2W-1:0] h2_d, h2_q;
  logic signed [SW-1:0]  slope4_d, slope4_q, slope5_q, slope_q;

  always_comb begin
    sum_h = MW2'(a1) <<< (2 * T);
    sum_q = (MW2'(a1) <<< (2 * T)) + (MW2'(1) <<< (2 * T - 1));
    for (int i = 0; i < NL1; i++) begin
      sum_h = sum_h + (MW2'(pph_q[i]) <<< (i * LIMB_W));
      sum_q = sum_q + (MW2'(ppq_q[i]) <<< (i * LIMB_W));
    end
    h2_d     = H2W'(sum_h);
    slope4_d = SW'(sum_q >>> (2 * T));
  end

  // stage 5: sliced product of the quadratic sum with t
  logic signed [XW2-1:0] h2_ext;
  logic signed [PPW-1:0] pp5_d [NL2];
  logic signed [PPW-1:0] pp5_q [NL2];

  always_comb begin
    h2_ext = XW2'(h2_q);
    for (int i = 0; i < NL2; i++) begin
      if (i == NL2 - 1) begin
        pp5_d[i] = $signed(h2_ext[i*LIMB_W +: LIMB_W]) * t4s;
      end else begin
        pp5_d[i] = $signed({1'b0, h2_ext[i*LIMB_W +: LIMB_W]}) * t4s;
      end
    end
  end

  // stage 6: gather slices, add constant term, round curve point
  logic signed [MW3-1:0] sum_p;
  logic signed [CW-1:0]  point_d, point_q;

  always_comb begin
    sum_p = (MW3'(a0) <<< (3 * T)) + (MW3'(1) <<< (3 * T - 1));
    for (int i = 0; i < NL2; i++) begin
      sum_p = sum_p + (MW3'(pp5_q[i]) <<< (i * LIMB_W));
    end
    point_d = CW'(sum_p >>> (3 * T));
  end

  // datapath registers, qualified by the valid bits in the top level
  always_ff @(posedge clk_i) begin
    p1_q     <= p1_d;
    h1_q     <= h1_d;
    q1_q     <= q1_d;
    bend2_q  <= bend2_d;
    pph_q    <= pph_d;
    ppq_q    <= ppq_d;
    bend3_q  <= bend2_q;
    h2_q     <= h2_d;
    slope4_q <= slope4_d;
    bend4_q  <= bend3_q;
    pp5_q    <= pp5_d;
    slope5_q <= slope4_q;
    bend5_q  <= bend4_q;
    point_q  <= point_d;
    slope_q  <= slope5_q;
    bend_q   <= bend5_q;
  end

  assign point_o = point_q;
  assign slope_o = slope_q;
  assign bend_o  = bend_q;

endmodule

// ----- hw/rtl/cubic_bezier_point_and_derivatives_unit.sv -----
// Cubic Bezier evaluator: for each parameter t (unsigned, 2^T_FRAC_BITS is 1.0, larger
// values clamp to 1.0) it returns the curve point and the first and second derivatives
// of all three axes, each rounded to nearest with ties toward +infinity in the
// coordinate scale. The block is a fully pipelined Horner evaluation in the power basis,
// so busy stays low and a new word may be started in every cycle; each result appears
// on the outputs with done_o high, one result per cycle, in order. The seven stages are
// set by three dependent multiplications by t; the second and third wide products are
// split into 24-bit slices whose partial products are summed in the following stage. The
// receiver cannot stall the pipeline. The user must write control points through the
// configuration port only while no word is in flight; the block does not enforce this.
module cubic_bezier_point_and_derivatives_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  cbz_pkg::cfg_idx_t               cfg_idx_i,
  input  logic        [3*COORD_WIDTH-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic        [T_FRAC_BITS:0]     param_t_i,
  output logic                            done_o,
  output logic signed [COORD_WIDTH-1:0]   point_x_o,
  output logic signed [COORD_WIDTH-1:0]   point_y_o,
  output logic signed [COORD_WIDTH-1:0]   point_z_o,
  output logic signed [COORD_WIDTH+2:0]   slope_x_o,
  output logic signed [COORD_WIDTH+2:0]   slope_y_o,
  output logic signed [COORD_WIDTH+2:0]   slope_z_o,
  output logic signed [COORD_WIDTH+4:0]   bend_x_o,
  output logic signed [COORD_WIDTH+4:0]   bend_y_o,
  output logic signed [COORD_WIDTH+4:0]   bend_z_o
);
  import cbz_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int TW     = T_FRAC_BITS + 1;
  localparam int STAGES = 7;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  // control point registers
  logic [3*CW-1:0] ctrl_q [NUM_CTRL_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CTRL_POINTS; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= CFG_CTRL_POINT_3)) begin
      ctrl_q[cfg_idx_i[1:0]] <= cfg_data_i;
    end
  end

  // pipeline always takes a word
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits travel alongside the datapath
  logic [STAGES-1:0] vld_d, vld_q;
  assign vld_d = {vld_q[STAGES-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[STAGES-1];

  // clamped parameter and its copies for the later multiply stages
  logic [TW-1:0] t0_d, t0_q, t1_q, t2_q, t3_q, t4_q;
  assign t0_d = (param_t_i > T_ONE) ? T_ONE : param_t_i;

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d;
    t1_q <= t0_q;
    t2_q <= t1_q;
    t3_q <= t2_q;
    t4_q <= t3_q;
  end

  // one datapath per axis
  logic signed [CW-1:0]   pt [NUM_AXES];
  logic signed [CW+2:0]   sl [NUM_AXES];
  logic signed [CW+4:0]   bd [NUM_AXES];

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    cbz_axis #(
      .COORD_WIDTH(COORD_WIDTH),
      .T_FRAC_BITS(T_FRAC_BITS)
    ) u_axis (
      .clk_i  (clk_i),
      .c0_i   ($signed(ctrl_q[0][k*CW +: CW])),
      .c1_i   ($signed(ctrl_q[1][k*CW +: CW])),
      .c2_i   ($signed(ctrl_q[2][k*CW +: CW])),
      .c3_i   ($signed(ctrl_q[3][k*CW +: CW])),
      .t_s0_i (t0_q),
      .t_s2_i (t2_q),
      .t_s4_i (t4_q),
      .point_o(pt[k]),
      .slope_o(sl[k]),
      .bend_o (bd[k])
    );
  end

  assign point_x_o = pt[0];
  assign point_y_o = pt[1];
  assign point_z_o = pt[2];
  assign slope_x_o = sl[0];
  assign slope_y_o = sl[1];
  assign slope_z_o = sl[2];
  assign bend_x_o  = bd[0];
  assign bend_y_o  = bd[1];
  assign bend_z_o  = bd[2];

endmodule
